/* rtl/directive_introducer_scanner_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the directive introducer scanner
// Concurrent assertions that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DIRECTIVE_INTRODUCER_SCANNER_CORE_MACROS_SVH
`define DIRECTIVE_INTRODUCER_SCANNER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define DIS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed in directive introducer scanner");

// Antecedent implies consequent in the following cycle.
`define DIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed in directive introducer scanner");

`else

`define DIS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/dis_pkg.sv */
// ----------------------------------------------------------------------------
// Directive introducer scanner package
// Shared types, constants and the byte classifier.
// ----------------------------------------------------------------------------
package dis_pkg;

    localparam int POSITION_BITS = 32;
    localparam int OFFSET_BITS   = 32;
    localparam int SUM_BITS      = ((POSITION_BITS > OFFSET_BITS) ? POSITION_BITS
                                                                   : OFFSET_BITS) + 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0]   OFF_MAX = {OFFSET_BITS{1'b1}};

    localparam logic [7:0] CHR_HASH  = 8'h23;
    localparam logic [7:0] CHR_BSL   = 8'h5C;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_VT    = 8'h0B;
    localparam logic [7:0] CHR_FF    = 8'h0C;

    typedef enum logic [2:0] {
        CLS_OTHER = 3'd0,
        CLS_HASH  = 3'd1,
        CLS_BSL   = 3'd2,
        CLS_CR    = 3'd3,
        CLS_LF    = 3'd4,
        CLS_HWS   = 3'd5,
        CLS_SLASH = 3'd6,
        CLS_STAR  = 3'd7
    } cls_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_BLOCK  = 3'b010,
        MODE_LINE   = 3'b100
    } mode_t;

    typedef enum logic [4:0] {
        PEND_NONE   = 5'b00001,
        PEND_SLASH  = 5'b00010,
        PEND_STAR   = 5'b00100,
        PEND_BSL    = 5'b01000,
        PEND_BSL_WS = 5'b10000
    } pend_t;

    typedef struct packed {
        cls_t                     cls;
        logic                     last;
        logic [POSITION_BITS-1:0] pos;
    } item_t;

    typedef struct packed {
        logic                 pop;
        logic                 last;
        logic                 reported;
        logic [QCNT_BITS-1:0] q_count;
    } scan_status_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t cls;
        case (c)
            CHR_HASH:                         cls = CLS_HASH;
            CHR_BSL:                          cls = CLS_BSL;
            CHR_CR:                           cls = CLS_CR;
            CHR_LF:                           cls = CLS_LF;
            CHR_SLASH:                        cls = CLS_SLASH;
            CHR_STAR:                         cls = CLS_STAR;
            CHR_SP, CHR_TAB, CHR_VT, CHR_FF:  cls = CLS_HWS;
            default:                          cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

/* rtl/dis_front.sv */
// ----------------------------------------------------------------------------
// Scanner front end
// Accepts bytes, classifies them and tags each with its position in the text.
// ----------------------------------------------------------------------------
module dis_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             q_full,
    output logic             q_push,
    output dis_pkg::item_t   q_item
);

    logic [dis_pkg::POSITION_BITS-1:0] pos_reg;
    logic [dis_pkg::POSITION_BITS-1:0] pos_next;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign q_item.cls  = dis_pkg::classify(s_tdata);
    assign q_item.last = s_tlast;
    assign q_item.pos  = pos_reg;

    // The position saturates and starts again at zero after the last word of a text.
    always_comb begin
        pos_next = pos_reg;
        if (q_push) begin
            if (s_tlast) begin
                pos_next = '0;
            end else if (pos_reg != dis_pkg::POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* rtl/dis_queue.sv */
// ----------------------------------------------------------------------------
// Scanner item queue
// Short FIFO that decouples the front end from the scan engine.
// ----------------------------------------------------------------------------
module dis_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  dis_pkg::item_t                push_item,
    output logic                          full,
    input  logic                          pop,
    output logic                          not_empty,
    output dis_pkg::item_t                head_item,
    output logic [dis_pkg::QCNT_BITS-1:0] count
);

    dis_pkg::item_t                    mem_reg [dis_pkg::QUEUE_DEPTH];
    logic [dis_pkg::QPTR_BITS-1:0]     wr_ptr_reg;
    logic [dis_pkg::QPTR_BITS-1:0]     wr_ptr_next;
    logic [dis_pkg::QPTR_BITS-1:0]     rd_ptr_reg;
    logic [dis_pkg::QPTR_BITS-1:0]     rd_ptr_next;
    logic [dis_pkg::QCNT_BITS-1:0]     count_reg;
    logic [dis_pkg::QCNT_BITS-1:0]     count_next;
    logic                              do_push;
    logic                              do_pop;

    localparam logic [dis_pkg::QPTR_BITS-1:0] PTR_LAST =
        dis_pkg::QPTR_BITS'(dis_pkg::QUEUE_DEPTH - 1);
    localparam logic [dis_pkg::QCNT_BITS-1:0] CNT_FULL =
        dis_pkg::QCNT_BITS'(dis_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/dis_back.sv */
// ----------------------------------------------------------------------------
// Scanner engine
// Runs the lexical state machine on classified bytes and registers the result.
// ----------------------------------------------------------------------------
module dis_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dis_pkg::OFFSET_BITS-1:0] cfg_wdata,
    input  logic                            q_not_empty,
    input  dis_pkg::item_t                  q_item,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dis_pkg::OFFSET_BITS-1:0] m_offset,
    output logic                            m_found,
    output logic                            st_reported
);

    logic [dis_pkg::OFFSET_BITS-1:0] base_reg;
    dis_pkg::mode_t                  mode_reg,  mode_next;
    dis_pkg::pend_t                  pend_reg,  pend_next;
    logic                            triv_reg,  triv_next;
    logic                            cbp_reg,   cbp_next;
    logic                            psr_reg,   psr_next;
    logic                            rep_reg,   rep_next;
    logic                            ovalid_reg;
    logic                            found_reg;
    logic [dis_pkg::OFFSET_BITS-1:0] offset_reg;

    dis_pkg::mode_t                  mode_s;
    dis_pkg::pend_t                  pend_s;
    logic                            triv_s, cbp_s, psr_s;
    logic                            hit;
    logic                            fresh;
    logic                            is_nl;
    logic                            emit;
    logic [dis_pkg::SUM_BITS-1:0]    sum;
    logic [dis_pkg::OFFSET_BITS-1:0] sat_offset;

    assign q_pop       = q_not_empty && (!ovalid_reg || m_tready);
    assign m_tvalid    = ovalid_reg;
    assign m_found     = found_reg;
    assign m_offset    = offset_reg;
    assign st_reported = rep_reg;

    assign is_nl = (q_item.cls == dis_pkg::CLS_CR) || (q_item.cls == dis_pkg::CLS_LF);

    // One step of the scanner for the byte at the head of the queue.
    always_comb begin
        mode_s = mode_reg;
        pend_s = pend_reg;
        triv_s = triv_reg;
        cbp_s  = cbp_reg;
        psr_s  = psr_reg;
        hit    = 1'b0;
        fresh  = 1'b1;
        if (psr_reg) begin
            psr_s = 1'b0;
            if (q_item.cls == dis_pkg::CLS_LF) begin
                fresh = 1'b0;
            end
        end
        if (fresh) begin
            case (pend_reg)
                dis_pkg::PEND_SLASH: begin
                    pend_s = dis_pkg::PEND_NONE;
                    if (q_item.cls == dis_pkg::CLS_STAR) begin
                        cbp_s  = triv_reg;
                        mode_s = dis_pkg::MODE_BLOCK;
                        fresh  = 1'b0;
                    end else if (q_item.cls == dis_pkg::CLS_SLASH) begin
                        mode_s = dis_pkg::MODE_LINE;
                        fresh  = 1'b0;
                    end else begin
                        triv_s = 1'b0;
                    end
                end
                dis_pkg::PEND_STAR: begin
                    pend_s = dis_pkg::PEND_NONE;
                    if (q_item.cls == dis_pkg::CLS_SLASH) begin
                        mode_s = dis_pkg::MODE_NORMAL;
                        fresh  = 1'b0;
                    end
                end
                dis_pkg::PEND_BSL, dis_pkg::PEND_BSL_WS: begin
                    if (q_item.cls == dis_pkg::CLS_HWS) begin
                        pend_s = dis_pkg::PEND_BSL_WS;
                        fresh  = 1'b0;
                    end else begin
                        pend_s = dis_pkg::PEND_NONE;
                        if (is_nl) begin
                            psr_s = (q_item.cls == dis_pkg::CLS_CR);
                            fresh = 1'b0;
                        end else if (mode_reg == dis_pkg::MODE_NORMAL) begin
                            triv_s = 1'b0;
                        end
                    end
                end
                default: begin
                    pend_s = dis_pkg::PEND_NONE;
                end
            endcase
        end
        // A byte with nothing left pending, judged in the mode it sees.
        if (fresh) begin
            if (q_item.cls == dis_pkg::CLS_BSL) begin
                pend_s = dis_pkg::PEND_BSL;
            end else begin
                case (mode_s)
                    dis_pkg::MODE_BLOCK: begin
                        if (q_item.cls == dis_pkg::CLS_STAR) begin
                            pend_s = dis_pkg::PEND_STAR;
                        end else if (is_nl) begin
                            triv_s = cbp_s;
                        end
                    end
                    dis_pkg::MODE_LINE: begin
                        if (is_nl) begin
                            mode_s = dis_pkg::MODE_NORMAL;
                            triv_s = 1'b1;
                        end
                    end
                    default: begin
                        if (q_item.cls == dis_pkg::CLS_SLASH) begin
                            pend_s = dis_pkg::PEND_SLASH;
                        end else if (is_nl) begin
                            triv_s = 1'b1;
                        end else if (triv_s && q_item.cls == dis_pkg::CLS_HWS) begin
                            triv_s = triv_s;
                        end else if (triv_s && q_item.cls == dis_pkg::CLS_HASH) begin
                            hit = 1'b1;
                        end else begin
                            triv_s = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    // The sum is wide enough that neither term can overflow it.
    assign sum = dis_pkg::SUM_BITS'(q_item.pos) + dis_pkg::SUM_BITS'(base_reg);
    assign sat_offset = (sum > dis_pkg::SUM_BITS'(dis_pkg::OFF_MAX)) ? dis_pkg::OFF_MAX
                                                                     : sum[dis_pkg::OFFSET_BITS-1:0];

    assign emit = q_pop && !rep_reg && (hit || q_item.last);

    always_comb begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        triv_next = triv_reg;
        cbp_next  = cbp_reg;
        psr_next  = psr_reg;
        rep_next  = rep_reg;
        if (q_pop) begin
            if (q_item.last) begin
                mode_next = dis_pkg::MODE_NORMAL;
                pend_next = dis_pkg::PEND_NONE;
                triv_next = 1'b1;
                cbp_next  = 1'b0;
                psr_next  = 1'b0;
                rep_next  = 1'b0;
            end else if (!rep_reg) begin
                mode_next = mode_s;
                pend_next = pend_s;
                triv_next = triv_s;
                cbp_next  = cbp_s;
                psr_next  = psr_s;
                rep_next  = hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            mode_reg   <= dis_pkg::MODE_NORMAL;
            pend_reg   <= dis_pkg::PEND_NONE;
            triv_reg   <= 1'b1;
            cbp_reg    <= 1'b0;
            psr_reg    <= 1'b0;
            rep_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            triv_reg <= triv_next;
            cbp_reg  <= cbp_next;
            psr_reg  <= psr_next;
            rep_reg  <= rep_next;
            if (emit) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            found_reg  <= hit;
            offset_reg <= hit ? sat_offset : '0;
        end
    end

endmodule

/* rtl/directive_introducer_scanner_core.sv */
// ----------------------------------------------------------------------------
// Directive introducer scanner
// Finds the first '#' in C source text that opens a preprocessing directive.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Contents
//  s_        in         s_tvalid / s_tready  one source byte, tlast ends the text
//  m_        out        m_tvalid / m_tready  hash offset, tuser says found
//  cfg_      in         cfg_we               base offset of the first byte
//
// One byte is taken in every cycle while the queue has room; the scan state
// machine settles each byte as it is popped, and the result register frees
// itself whenever it is taken. A result passes through a queue entry and then
// the result register after the word that causes it is accepted. Reset is
// synchronous and active low; no clearing pass. A stalled result holds the
// engine, and the two-entry queue then fills and deasserts s_tready.
//
`include "directive_introducer_scanner_core_macros.svh"

module directive_introducer_scanner_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] hash_offset
    output logic [0:0]  m_tuser    // [0] found
);

    logic                    q_push;
    logic                    q_full;
    logic                    q_not_empty;
    logic                    q_pop;
    dis_pkg::item_t          push_item;
    dis_pkg::item_t          head_item;
    dis_pkg::scan_status_t   status;
    logic [dis_pkg::QCNT_BITS-1:0] q_count;
    logic                    reported;
    logic                    found;

    dis_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    dis_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item),
        .count     (q_count)
    );

    dis_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_offset    (m_tdata),
        .m_found     (found),
        .st_reported (reported)
    );

    assign m_tuser[0] = found;

    assign status.pop      = q_pop;
    assign status.last     = head_item.last;
    assign status.reported = reported;
    assign status.q_count  = q_count;

    // The last word of a text that has not yet reported always yields a result.
    `DIS_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, status.pop && status.last && !status.reported, m_tvalid)
    // A not-found result carries a zero offset.
    `DIS_ASSERT_SAME(a_not_found_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 32'd0)
    // The queue never holds more words than it has entries.
    `DIS_ASSERT_SAME(a_queue_bound, aclk, aresetn, 1'b1, status.q_count <= dis_pkg::QCNT_BITS'(dis_pkg::QUEUE_DEPTH))

endmodule
